// ----- hw/rtl/multi_axis_homing_sequencer_macros.svh -----
// Assertion helpers for the homing sequencer
`ifndef MULTI_AXIS_HOMING_SEQUENCER_MACROS_SVH
`define MULTI_AXIS_HOMING_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MAHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MAHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mahs_pkg.sv -----
`default_nettype none
package mahs_pkg;

  localparam int AXES       = 8;
  localparam int AXIS_IDX_W = $clog2(AXES);
  localparam int AXIS_W     = 4;
  localparam int CNT_W      = 4;
  localparam int SPEED_W    = 24;
  localparam int BACKOFF_W  = 16;
  localparam int DIST_W     = 18;
  localparam int MASK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0]   AXES_CNT  = CNT_W'(AXES);
  localparam logic [DIST_W-1:0]  LONG_MOVE = DIST_W'(100000);

  localparam logic [CNT_W-1:0]     RST_AXES_IN_USE = 4'd8;
  localparam logic [SPEED_W-1:0]   RST_SEARCH      = 24'd1000;
  localparam logic [SPEED_W-1:0]   RST_CREEP       = 24'd100;
  localparam logic [BACKOFF_W-1:0] RST_BACKOFF     = 16'd200;
  localparam logic [MASK_W-1:0]    RST_INV_LIMIT   = 8'hFF;
  localparam logic [MASK_W-1:0]    RST_INV_DIR     = 8'h00;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_SEARCH  = 3'd1;
  localparam phase_t PH_BACKOFF = 3'd2;
  localparam phase_t PH_CREEP   = 3'd3;
  localparam phase_t PH_FOUND   = 3'd4;
  localparam phase_t PH_ERROR   = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_UPDATE = 2'd0;
  localparam kind_t KIND_START  = 2'd1;
  localparam kind_t KIND_STOP   = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_AXES_IN_USE = 3'd0;
  localparam cfg_idx_t CFG_SEARCH      = 3'd1;
  localparam cfg_idx_t CFG_CREEP       = 3'd2;
  localparam cfg_idx_t CFG_BACKOFF     = 3'd3;
  localparam cfg_idx_t CFG_INV_LIMIT   = 3'd4;
  localparam cfg_idx_t CFG_INV_DIR     = 3'd5;

endpackage
`default_nettype wire

// ----- hw/rtl/multi_axis_homing_sequencer.sv -----
// Multi-axis limit-switch homing sequencer.
// Input channel (in_valid/in_ready): one request names an axis, a kind
// (update, start, stop, clear homed), the raw switch level and whether the
// profiler reports that axis moving. Result channel (out_valid/out_ready):
// exactly one result per request, in request order, carrying the motion
// commands for that axis and its status after the request.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata writes one register;
// write only while no request is in flight.
// Path: an accepted request enters the input register, then moves into the
// result register, where out_valid rises and the result can be taken.
// Throughput: one request per cycle while results are taken; the per-axis
// phase and homed flags are read and updated in the same cycle the request
// moves into the result register, so consecutive requests to one axis see
// each other's effects.
// Reset: all axes idle and not homed, registers at their defaults, both
// register stages empty.
// Receiver stall: the result register holds; one more request waits in the
// input register, then in_ready drops until out_ready returns.
`default_nettype none
module multi_axis_homing_sequencer (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire  [mahs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [mahs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [1:0]                            in_kind,
  input  wire  [mahs_pkg::AXIS_W-1:0]           in_axis,
  input  wire                                   in_limit_raw,
  input  wire                                   in_axis_moving,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [mahs_pkg::AXIS_W-1:0]           out_command_axis,
  output logic                                  out_stop_motion,
  output logic                                  out_set_limits,
  output logic [mahs_pkg::SPEED_W-1:0]          out_speed_limit,
  output logic [mahs_pkg::SPEED_W-1:0]          out_accel_limit,
  output logic                                  out_start_move,
  output logic signed [mahs_pkg::DIST_W-1:0]    out_move_distance,
  output logic                                  out_zero_position,
  output logic                                  out_homing_done,
  output logic [2:0]                            out_axis_state,
  output logic                                  out_axis_homed,
  output logic                                  out_any_active
);

  logic [mahs_pkg::CNT_W-1:0]     axes_in_use_r;
  logic [mahs_pkg::SPEED_W-1:0]   search_speed_r;
  logic [mahs_pkg::SPEED_W-1:0]   creep_speed_r;
  logic [mahs_pkg::BACKOFF_W-1:0] backoff_r;
  logic [mahs_pkg::MASK_W-1:0]    inv_limit_r;
  logic [mahs_pkg::MASK_W-1:0]    inv_dir_r;

  mahs_pkg::phase_t               phase_r   [mahs_pkg::AXES];
  mahs_pkg::phase_t               phase_nxt [mahs_pkg::AXES];
  logic [mahs_pkg::AXES-1:0]      homed_r;
  logic [mahs_pkg::AXES-1:0]      homed_nxt;

  logic                           req_valid_r;
  mahs_pkg::kind_t                req_kind_r;
  logic [mahs_pkg::AXIS_W-1:0]    req_axis_r;
  logic                           req_limit_r;
  logic                           req_moving_r;

  logic                           out_valid_r;
  logic [mahs_pkg::AXIS_W-1:0]    axis_r;
  logic                           stop_r, setl_r, move_r, zero_r, done_r, homed_out_r;
  logic                           active_r;
  logic [mahs_pkg::SPEED_W-1:0]   speed_r, accel_r;
  logic [mahs_pkg::DIST_W-1:0]    dist_r;
  mahs_pkg::phase_t               state_r;

  logic                           advance;
  logic [mahs_pkg::CNT_W-1:0]     n_eff;
  logic                           axis_ok;
  logic [mahs_pkg::AXIS_IDX_W-1:0] idx;
  logic                           dir_pos, hit;
  mahs_pkg::phase_t               cur;
  logic                           stop_nxt, setl_nxt, move_nxt, zero_nxt;
  logic                           done_nxt, homed_out_nxt, active_nxt;
  logic [mahs_pkg::SPEED_W-1:0]   speed_nxt, accel_nxt;
  logic [mahs_pkg::DIST_W-1:0]    dist_nxt;
  mahs_pkg::phase_t               state_nxt;

  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  assign n_eff   = (axes_in_use_r > mahs_pkg::AXES_CNT) ? mahs_pkg::AXES_CNT : axes_in_use_r;
  assign axis_ok = (req_axis_r < n_eff);
  assign idx     = req_axis_r[mahs_pkg::AXIS_IDX_W-1:0];
  assign dir_pos = inv_dir_r[idx];
  assign hit     = inv_limit_r[idx] ? !req_limit_r : req_limit_r;
  assign cur     = phase_r[idx];

  always_comb begin
    for (int i = 0; i < mahs_pkg::AXES; i++) begin
      phase_nxt[i] = phase_r[i];
    end
    homed_nxt     = homed_r;
    stop_nxt      = 1'b0;
    setl_nxt      = 1'b0;
    move_nxt      = 1'b0;
    zero_nxt      = 1'b0;
    speed_nxt     = '0;
    accel_nxt     = '0;
    dist_nxt      = '0;
    if (axis_ok) begin
      unique case (req_kind_r)
        mahs_pkg::KIND_START: begin
          phase_nxt[idx] = mahs_pkg::PH_SEARCH;
          homed_nxt[idx] = 1'b0;
          setl_nxt       = 1'b1;
          speed_nxt      = search_speed_r;
          accel_nxt      = search_speed_r;
          move_nxt       = 1'b1;
          dist_nxt       = dir_pos ? mahs_pkg::LONG_MOVE : -mahs_pkg::LONG_MOVE;
        end
        mahs_pkg::KIND_STOP: begin
          phase_nxt[idx] = mahs_pkg::PH_IDLE;
          stop_nxt       = 1'b1;
        end
        mahs_pkg::KIND_CLEAR: begin
          homed_nxt[idx] = 1'b0;
        end
        default: begin
          unique case (cur)
            mahs_pkg::PH_SEARCH: begin
              if (hit) begin
                stop_nxt       = 1'b1;
                setl_nxt       = 1'b1;
                speed_nxt      = creep_speed_r;
                accel_nxt      = creep_speed_r;
                move_nxt       = 1'b1;
                dist_nxt       = dir_pos ? -{2'b00, backoff_r} : {2'b00, backoff_r};
                phase_nxt[idx] = mahs_pkg::PH_BACKOFF;
              end
            end
            mahs_pkg::PH_BACKOFF: begin
              if (!req_moving_r) begin
                setl_nxt       = 1'b1;
                speed_nxt      = creep_speed_r;
                accel_nxt      = creep_speed_r >> 1;
                move_nxt       = 1'b1;
                dist_nxt       = dir_pos ? mahs_pkg::LONG_MOVE : -mahs_pkg::LONG_MOVE;
                phase_nxt[idx] = mahs_pkg::PH_CREEP;
              end
            end
            mahs_pkg::PH_CREEP: begin
              if (hit) begin
                stop_nxt       = 1'b1;
                zero_nxt       = 1'b1;
                homed_nxt[idx] = 1'b1;
                phase_nxt[idx] = mahs_pkg::PH_FOUND;
              end else if (!req_moving_r) begin
                phase_nxt[idx] = mahs_pkg::PH_ERROR;
              end
            end
            default: begin
            end
          endcase
        end
      endcase
    end
    state_nxt     = axis_ok ? phase_nxt[idx] : mahs_pkg::PH_IDLE;
    homed_out_nxt = axis_ok && homed_nxt[idx];
    done_nxt      = axis_ok && (phase_nxt[idx] == mahs_pkg::PH_FOUND);
    active_nxt    = 1'b0;
    for (int i = 0; i < mahs_pkg::AXES; i++) begin
      if ((mahs_pkg::CNT_W'(i) < n_eff) &&
          ((phase_nxt[i] == mahs_pkg::PH_SEARCH) || (phase_nxt[i] == mahs_pkg::PH_BACKOFF) ||
           (phase_nxt[i] == mahs_pkg::PH_CREEP))) begin
        active_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axes_in_use_r  <= mahs_pkg::RST_AXES_IN_USE;
      search_speed_r <= mahs_pkg::RST_SEARCH;
      creep_speed_r  <= mahs_pkg::RST_CREEP;
      backoff_r      <= mahs_pkg::RST_BACKOFF;
      inv_limit_r    <= mahs_pkg::RST_INV_LIMIT;
      inv_dir_r      <= mahs_pkg::RST_INV_DIR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mahs_pkg::CFG_AXES_IN_USE: axes_in_use_r  <= cfg_wdata[mahs_pkg::CNT_W-1:0];
        mahs_pkg::CFG_SEARCH:      search_speed_r <= cfg_wdata[mahs_pkg::SPEED_W-1:0];
        mahs_pkg::CFG_CREEP:       creep_speed_r  <= cfg_wdata[mahs_pkg::SPEED_W-1:0];
        mahs_pkg::CFG_BACKOFF:     backoff_r      <= cfg_wdata[mahs_pkg::BACKOFF_W-1:0];
        mahs_pkg::CFG_INV_LIMIT:   inv_limit_r    <= cfg_wdata[mahs_pkg::MASK_W-1:0];
        mahs_pkg::CFG_INV_DIR:     inv_dir_r      <= cfg_wdata[mahs_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mahs_pkg::AXES; i++) begin
        phase_r[i] <= mahs_pkg::PH_IDLE;
      end
      homed_r     <= '0;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        for (int i = 0; i < mahs_pkg::AXES; i++) begin
          phase_r[i] <= phase_nxt[i];
        end
        homed_r     <= homed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_kind_r   <= in_kind;
      req_axis_r   <= in_axis;
      req_limit_r  <= in_limit_raw;
      req_moving_r <= in_axis_moving;
    end
    if (advance) begin
      axis_r      <= req_axis_r;
      stop_r      <= stop_nxt;
      setl_r      <= setl_nxt;
      speed_r     <= speed_nxt;
      accel_r     <= accel_nxt;
      move_r      <= move_nxt;
      dist_r      <= dist_nxt;
      zero_r      <= zero_nxt;
      done_r      <= done_nxt;
      state_r     <= state_nxt;
      homed_out_r <= homed_out_nxt;
      active_r    <= active_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_axis  = axis_r;
  assign out_stop_motion   = stop_r;
  assign out_set_limits    = setl_r;
  assign out_speed_limit   = speed_r;
  assign out_accel_limit   = accel_r;
  assign out_start_move    = move_r;
  assign out_move_distance = dist_r;
  assign out_zero_position = zero_r;
  assign out_homing_done   = done_r;
  assign out_axis_state    = state_r;
  assign out_axis_homed    = homed_out_r;
  assign out_any_active    = active_r;

`include "multi_axis_homing_sequencer_macros.svh"

  `MAHS_ASSERT_NOW(a_zero_means_found, out_valid_r && zero_r,
                   done_r && stop_r && homed_out_r, "zero without found")
  `MAHS_ASSERT_NOW(a_move_has_limits, out_valid_r && move_r, setl_r,
                   "move issued without limits")
  `MAHS_ASSERT_NOW(a_active_reported,
                   out_valid_r && ((state_r == mahs_pkg::PH_SEARCH) ||
                   (state_r == mahs_pkg::PH_BACKOFF) || (state_r == mahs_pkg::PH_CREEP)),
                   active_r, "active axis not in any_active")
  `MAHS_ASSERT_NEXT(a_req_held_on_stall, req_valid_r && out_valid_r && !out_ready,
                    req_valid_r && $stable(req_axis_r) && $stable(req_kind_r),
                    "held request lost")

endmodule
`default_nettype wire
